### rtl/aec_pkg.sv
// ---------------------------------------------------------------------------
// aec_pkg: shared types and helpers for the escape-sequence parser
// Byte classes, command kinds, parser phases and the SGR attribute rule.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aec_pkg;

  localparam int MAX_PARAMS = 8;
  localparam int PARAM_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int ACC_W      = PARAM_BITS + 4;

  localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] ATTR_COLOR = 8'h77;

  // Configuration register indexes.
  localparam logic CFG_PASSTHROUGH = 1'b0;
  localparam logic CFG_START_ATTR  = 1'b1;

  // Parameter codes that h/l with the '?' marker react to.
  localparam logic [PARAM_BITS-1:0] PM_COLUMNS = PARAM_BITS'(3);
  localparam logic [PARAM_BITS-1:0] PM_INVERSE = PARAM_BITS'(5);
  localparam logic [PARAM_BITS-1:0] PM_CURSOR  = PARAM_BITS'(25);
  localparam logic [PARAM_BITS-1:0] PM_HOME    = PARAM_BITS'(47);

  typedef enum logic [2:0] {
    KIND_PRINT, KIND_ATTR, KIND_ERASE_LINE, KIND_ERASE_DISP,
    KIND_CURSOR, KIND_VISIBLE, KIND_COLUMNS, KIND_HOME
  } kind_t;

  typedef enum logic [3:0] {
    BC_ESC, BC_NUL, BC_DIGIT, BC_BRACKET, BC_SEMI, BC_GT, BC_QMARK, BC_SGR,
    BC_SET, BC_RESET, BC_ERASE_LINE, BC_ERASE_DISP, BC_CURSOR, BC_OTHER
  } byte_class_t;

  typedef enum logic [1:0] {PH_IDLE, PH_SEQ, PH_DROP} phase_t;
  typedef enum logic [1:0] {MK_NONE, MK_GT, MK_Q} marker_t;
  typedef enum logic [1:0] {CS_READY, CS_SGR, CS_MODE} ctrl_state_t;

  typedef struct packed {
    logic        accept;
    logic        clear_params;
    logic        digit;
    logic        next_param;
    logic        set_gt;
    logic        set_q;
    logic        walk_start;
    logic        walk_step;
    logic        sgr_step;
    logic        mode_step;
    logic        load_out;
    kind_t       out_kind;
    logic [1:0]  out_mode;
    logic        out_last;
  } cmd_t;

  typedef struct packed {
    logic        in_valid;
    logic        in_end;
    byte_class_t cls;
    logic        passthrough;
    logic        idx_last;
    marker_t     marker;
    logic        gt5;
    logic [1:0]  erase_mode;
    logic        walk_last;
    logic        walk_emit;
    logic        walk_later;
    kind_t       walk_kind;
    logic [1:0]  walk_mode;
    logic        out_free;
  } status_t;

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t r;
    r = BC_OTHER;
    if (c == ESC_BYTE)                   r = BC_ESC;
    else if (c == 8'h00)                 r = BC_NUL;
    else if (c >= "0" && c <= "9")       r = BC_DIGIT;
    else if (c == "[")                   r = BC_BRACKET;
    else if (c == ";")                   r = BC_SEMI;
    else if (c == ">")                   r = BC_GT;
    else if (c == "?")                   r = BC_QMARK;
    else if (c == "m")                   r = BC_SGR;
    else if (c == "h")                   r = BC_SET;
    else if (c == "l")                   r = BC_RESET;
    else if (c == "K")                   r = BC_ERASE_LINE;
    else if (c == "J")                   r = BC_ERASE_DISP;
    else if (c == "H")                   r = BC_CURSOR;
    return r;
  endfunction

  function automatic logic [7:0] swap_nibbles(input logic [7:0] a);
    return {a[3:0], a[7:4]};
  endfunction

  // One SGR parameter applied to the attribute; rst holds the color bits.
  function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic pres,
                                           input logic [PARAM_BITS-1:0] v,
                                           input logic [7:0] rst);
    logic [7:0] r;
    logic [2:0] k;
    r = a;
    k = 3'(v);
    if (!pres || v == '0)                       r = rst;
    else if (v == 1 || v == 4)                  r = a | 8'h08;
    else if (v == 5)                            r = a | 8'h80;
    else if (v == 7 || v == 27)                 r = swap_nibbles(a);
    else if (v == 22 || v == 24)                r = a & 8'hF7;
    else if (v == 25)                           r = a & 8'h7F;
    else if (v >= 30 && v <= 37) begin
      k = 3'(v - PARAM_BITS'(30));
      r = {a[7:3], k[0], k[1], k[2]};
    end else if (v == 39)                       r = {a[7:4], 1'b0, rst[2:0]};
    else if (v >= 40 && v <= 47) begin
      k = 3'(v - PARAM_BITS'(40));
      r = {a[7], k[0], k[1], k[2], a[3:0]};
    end else if (v == 49)                       r = {1'b0, rst[6:4], a[3:0]};
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/aec_in_if.sv
// ---------------------------------------------------------------------------
// aec_in_if: text byte channel
// Valid/ready channel carrying one text byte and its end-of-message flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       message_end;
  modport source (output valid, text_byte, message_end, input ready);
  modport sink   (input valid, text_byte, message_end, output ready);
endinterface

`default_nettype wire

### rtl/aec_out_if.sv
// ---------------------------------------------------------------------------
// aec_out_if: console command channel
// Valid/ready channel carrying one console command word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aec_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_char;
  logic [7:0]  attribute;
  logic [1:0]  mode;
  logic [15:0] first_param;
  logic        first_given;
  logic [15:0] second_param;
  logic        second_given;
  logic        last_of_run;
  modport source (output valid, kind, out_char, attribute, mode, first_param,
                  first_given, second_param, second_given, last_of_run,
                  input ready);
  modport sink   (input valid, kind, out_char, attribute, mode, first_param,
                  first_given, second_param, second_given, last_of_run,
                  output ready);
endinterface

`default_nettype wire

### rtl/aec_ctrl.sv
// ---------------------------------------------------------------------------
// aec_ctrl: parser controller
// Tracks the parse phase and sequences parameter walks for SGR and h/l.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aec_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  aec_pkg::status_t st,
  output aec_pkg::cmd_t    cmd,
  output logic             in_ready
);

  aec_pkg::ctrl_state_t state_r, state_nxt;
  aec_pkg::phase_t      phase_r, phase_nxt;
  logic                 accept;
  logic                 step_ok;

  assign in_ready = (state_r == aec_pkg::CS_READY) && st.out_free;
  assign accept   = in_ready && st.in_valid;

  // A walk step may only proceed when any result it makes has room.
  always_comb begin
    step_ok = 1'b0;
    if (state_r == aec_pkg::CS_SGR)       step_ok = !st.walk_last || st.out_free;
    else if (state_r == aec_pkg::CS_MODE) step_ok = !st.walk_emit || st.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      aec_pkg::CS_READY: begin
        if (accept && !st.passthrough) begin
          unique case (phase_r)
            aec_pkg::PH_IDLE: begin
              if (st.cls == aec_pkg::BC_ESC)      phase_nxt = aec_pkg::PH_SEQ;
              else if (st.cls == aec_pkg::BC_NUL) phase_nxt = aec_pkg::PH_DROP;
            end
            aec_pkg::PH_SEQ: begin
              case (st.cls)
                aec_pkg::BC_NUL: phase_nxt = aec_pkg::PH_DROP;
                aec_pkg::BC_SEMI: begin
                  if (st.idx_last) phase_nxt = aec_pkg::PH_DROP;
                end
                aec_pkg::BC_DIGIT, aec_pkg::BC_BRACKET, aec_pkg::BC_GT,
                aec_pkg::BC_QMARK: ;
                default: begin
                  phase_nxt = aec_pkg::PH_IDLE;
                  if (st.cls == aec_pkg::BC_SGR) state_nxt = aec_pkg::CS_SGR;
                  else if ((st.cls == aec_pkg::BC_SET || st.cls == aec_pkg::BC_RESET)
                           && st.marker == aec_pkg::MK_Q)
                    state_nxt = aec_pkg::CS_MODE;
                end
              endcase
            end
            default: ;
          endcase
        end
        if (accept && st.in_end) phase_nxt = aec_pkg::PH_IDLE;
      end
      aec_pkg::CS_SGR, aec_pkg::CS_MODE: begin
        if (step_ok && st.walk_last) state_nxt = aec_pkg::CS_READY;
      end
      default: state_nxt = aec_pkg::CS_READY;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.out_kind = aec_pkg::KIND_PRINT;
    cmd.accept   = accept;
    unique case (state_r)
      aec_pkg::CS_READY: begin
        if (accept) begin
          if (st.passthrough) begin
            cmd.load_out = 1'b1;
            cmd.out_last = 1'b1;
          end else if (phase_r == aec_pkg::PH_IDLE) begin
            if (st.cls == aec_pkg::BC_ESC) cmd.clear_params = 1'b1;
            else if (st.cls != aec_pkg::BC_NUL) begin
              cmd.load_out = 1'b1;
              cmd.out_last = 1'b1;
            end
          end else if (phase_r == aec_pkg::PH_SEQ) begin
            case (st.cls)
              aec_pkg::BC_DIGIT: cmd.digit = 1'b1;
              aec_pkg::BC_SEMI:  cmd.next_param = !st.idx_last;
              aec_pkg::BC_GT:    cmd.set_gt = 1'b1;
              aec_pkg::BC_QMARK: cmd.set_q = 1'b1;
              aec_pkg::BC_SGR:   cmd.walk_start = 1'b1;
              aec_pkg::BC_SET, aec_pkg::BC_RESET: begin
                if (st.marker == aec_pkg::MK_Q) cmd.walk_start = 1'b1;
                else if (st.gt5) begin
                  cmd.load_out = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_kind = aec_pkg::KIND_VISIBLE;
                  cmd.out_mode = {1'b0, st.cls == aec_pkg::BC_RESET};
                end
              end
              aec_pkg::BC_ERASE_LINE, aec_pkg::BC_ERASE_DISP: begin
                cmd.load_out = 1'b1;
                cmd.out_last = 1'b1;
                cmd.out_mode = st.erase_mode;
                cmd.out_kind = (st.cls == aec_pkg::BC_ERASE_LINE) ?
                               aec_pkg::KIND_ERASE_LINE : aec_pkg::KIND_ERASE_DISP;
              end
              aec_pkg::BC_CURSOR: begin
                cmd.load_out = 1'b1;
                cmd.out_last = 1'b1;
                cmd.out_kind = aec_pkg::KIND_CURSOR;
              end
              default: ;
            endcase
          end
        end
      end
      aec_pkg::CS_SGR: begin
        if (step_ok) begin
          cmd.walk_step = 1'b1;
          cmd.sgr_step  = 1'b1;
          if (st.walk_last) begin
            cmd.load_out = 1'b1;
            cmd.out_last = 1'b1;
            cmd.out_kind = aec_pkg::KIND_ATTR;
          end
        end
      end
      aec_pkg::CS_MODE: begin
        if (step_ok) begin
          cmd.walk_step = 1'b1;
          cmd.mode_step = 1'b1;
          if (st.walk_emit) begin
            cmd.load_out = 1'b1;
            cmd.out_last = !st.walk_later;
            cmd.out_kind = st.walk_kind;
            cmd.out_mode = st.walk_mode;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aec_pkg::CS_READY;
      phase_r <= aec_pkg::PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/aec_dp.sv
// ---------------------------------------------------------------------------
// aec_dp: parser datapath
// Parameter store, attribute, configuration and the output word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aec_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire                   cfg_index,
  input  wire  [7:0]            cfg_data,
  input  wire                   in_valid,
  input  wire  [7:0]            in_text_byte,
  input  wire                   in_message_end,
  input  aec_pkg::cmd_t         cmd,
  output aec_pkg::status_t      st,
  input  wire                   out_ready,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_char,
  output logic [7:0]            out_attribute,
  output logic [1:0]            out_mode,
  output logic [15:0]           out_first_param,
  output logic                  out_first_given,
  output logic [15:0]           out_second_param,
  output logic                  out_second_given,
  output logic                  out_last_of_run
);

  localparam int PB = aec_pkg::PARAM_BITS;
  localparam int IW = aec_pkg::IDX_W;
  localparam int NP = aec_pkg::MAX_PARAMS;

  logic [PB-1:0]       val_r [NP];
  logic [NP-1:0]       pres_r;
  logic [PB-1:0]       acc_r;
  logic                pres_cur_r;
  logic [IW-1:0]       idx_r;
  aec_pkg::marker_t    marker_r;
  logic [7:0]          attr_r, attr_nxt;
  logic [7:0]          start_r;
  logic                pass_r;
  logic [IW-1:0]       walk_r;
  logic                walk_set_r;
  logic                out_valid_r;

  logic [PB-1:0]       pv   [NP];
  logic [NP-1:0]       pp;
  logic [NP-1:0]       emit_mask;
  logic [PB-1:0]       wv;
  logic                wp;
  logic [aec_pkg::ACC_W-1:0] acc_sum;
  logic [PB-1:0]       acc_nxt;
  logic [3:0]          digit;
  logic                out_free;
  logic                later;

  // The slot being filled lives in the accumulator; earlier slots in val_r.
  always_comb begin
    for (int j = 0; j < NP; j++) begin
      if (IW'(j) == idx_r) begin
        pv[j] = acc_r;
        pp[j] = pres_cur_r;
      end else begin
        pv[j] = val_r[j];
        pp[j] = pres_r[j] && (IW'(j) < idx_r);
      end
      emit_mask[j] = pp[j] && (pv[j] == aec_pkg::PM_COLUMNS ||
                               pv[j] == aec_pkg::PM_INVERSE ||
                               pv[j] == aec_pkg::PM_CURSOR ||
                               (pv[j] == aec_pkg::PM_HOME && walk_set_r));
    end
  end

  always_comb begin
    later = 1'b0;
    for (int j = 0; j < NP; j++) begin
      if (IW'(j) > walk_r && IW'(j) <= idx_r) later = later | emit_mask[j];
    end
  end

  assign wv = pv[walk_r];
  assign wp = pp[walk_r];

  assign digit   = 4'(in_text_byte - 8'h30);
  assign acc_sum = aec_pkg::ACC_W'({acc_r, 3'b000}) + aec_pkg::ACC_W'({acc_r, 1'b0})
                   + aec_pkg::ACC_W'(digit);
  assign acc_nxt = !pres_cur_r ? PB'(digit) :
                   (acc_sum > aec_pkg::ACC_W'(aec_pkg::PARAM_MAX)) ? aec_pkg::PARAM_MAX
                                                                   : acc_sum[PB-1:0];

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    attr_nxt = attr_r;
    if (cmd.sgr_step)
      attr_nxt = aec_pkg::sgr_apply(attr_r, wp, wv, start_r & aec_pkg::ATTR_COLOR);
    else if (cmd.mode_step && wp && wv == aec_pkg::PM_INVERSE)
      attr_nxt = aec_pkg::swap_nibbles(attr_r);
  end

  always_comb begin
    st            = '0;
    st.in_valid   = in_valid;
    st.in_end     = in_message_end;
    st.cls        = aec_pkg::classify(in_text_byte);
    st.passthrough = pass_r;
    st.idx_last   = (idx_r == IW'(NP - 1));
    st.marker     = marker_r;
    st.gt5        = (marker_r == aec_pkg::MK_GT) && pp[0] && pv[0] == PB'(5);
    st.erase_mode = (pp[0] && (pv[0] == PB'(1) || pv[0] == PB'(2))) ? pv[0][1:0] : 2'd0;
    st.walk_last  = (walk_r == idx_r);
    st.walk_emit  = emit_mask[walk_r];
    st.walk_later = later;
    st.walk_mode  = 2'd0;
    st.walk_kind  = aec_pkg::KIND_HOME;
    if (wv == aec_pkg::PM_COLUMNS) begin
      st.walk_kind = aec_pkg::KIND_COLUMNS;
      st.walk_mode = {1'b0, walk_set_r};
    end else if (wv == aec_pkg::PM_INVERSE) begin
      st.walk_kind = aec_pkg::KIND_ATTR;
    end else if (wv == aec_pkg::PM_CURSOR) begin
      st.walk_kind = aec_pkg::KIND_VISIBLE;
      st.walk_mode = {1'b0, walk_set_r};
    end
    st.out_free   = out_free;
  end

  // Parameter store: values need no reset, presence is cleared by ESC.
  always_ff @(posedge clk) begin
    if (cmd.next_param) val_r[idx_r] <= acc_r;
    if (cmd.digit)      acc_r <= acc_nxt;
    if (cmd.walk_start) walk_set_r <= (st.cls == aec_pkg::BC_SET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r     <= '0;
      pres_cur_r <= 1'b0;
      idx_r      <= '0;
      marker_r   <= aec_pkg::MK_NONE;
      walk_r     <= '0;
      pass_r     <= 1'b0;
      start_r    <= 8'd7;
      attr_r     <= 8'd7;
    end else begin
      // Writing the start attribute also reloads the current one.
      if (cfg_we && cfg_index == aec_pkg::CFG_START_ATTR) attr_r <= cfg_data;
      else attr_r <= attr_nxt;
      if (cmd.clear_params) begin
        pres_r     <= '0;
        pres_cur_r <= 1'b0;
        idx_r      <= '0;
        marker_r   <= aec_pkg::MK_NONE;
      end
      if (cmd.digit) pres_cur_r <= 1'b1;
      if (cmd.next_param) begin
        pres_r[idx_r] <= pres_cur_r;
        pres_cur_r    <= 1'b0;
        idx_r         <= idx_r + 1'b1;
      end
      if (cmd.set_gt) marker_r <= aec_pkg::MK_GT;
      if (cmd.set_q)  marker_r <= aec_pkg::MK_Q;
      if (cmd.walk_start)     walk_r <= '0;
      else if (cmd.walk_step) walk_r <= walk_r + 1'b1;
      if (cfg_we) begin
        if (cfg_index == aec_pkg::CFG_PASSTHROUGH) pass_r <= cfg_data[0];
        else start_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind         <= cmd.out_kind;
      out_char         <= (cmd.out_kind == aec_pkg::KIND_PRINT) ? in_text_byte : 8'd0;
      out_attribute    <= attr_nxt;
      out_mode         <= cmd.out_mode;
      out_last_of_run  <= cmd.out_last;
      if (cmd.out_kind == aec_pkg::KIND_CURSOR) begin
        out_first_param  <= pp[0] ? 16'(pv[0]) : 16'd0;
        out_first_given  <= pp[0];
        out_second_param <= pp[1] ? 16'(pv[1]) : 16'd0;
        out_second_given <= pp[1];
      end else begin
        out_first_param  <= 16'd0;
        out_first_given  <= 1'b0;
        out_second_param <= 16'd0;
        out_second_given <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/ansi_escape_to_console_commands_unit.sv
// ---------------------------------------------------------------------------
// ansi_escape_to_console_commands_unit: escape-sequence to console commands
// Turns a text byte stream into print, attribute, erase and cursor words.
// ---------------------------------------------------------------------------
// Usage: bytes enter on in_ch (text_byte, message_end) and command words
// leave on out_ch; a word moves when valid and ready are both high. The
// cfg port writes register 0 (passthrough) and 1 (start attribute, which
// also reloads the current attribute); the user must write only while the
// block is idle, a check the block leaves to the user. A byte that makes
// a word by itself shows it on out_ch in the cycle after it is accepted;
// ordinary bytes are taken back to back. An 'm' final byte walks the
// stored parameters (up to 8) one per cycle, pausing only while its word
// finds out_ch full; h/l with the '?' marker walk the same way, pausing
// likewise, and send at most one word per parameter. The output word
// register frees the input side as soon as the word it holds is taken or
// about to be taken. Reset (rst_n low at a clock edge) returns the parser
// to plain text, passthrough off and the attribute to 7. When out_ch
// stalls, the held word stays stable and in_ch.ready drops until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module ansi_escape_to_console_commands_unit (
  input  wire        clk,
  input  wire        rst_n,
  aec_in_if.sink     in_ch,
  aec_out_if.source  out_ch,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire  [7:0] cfg_data
);

  aec_pkg::cmd_t    cmd;
  aec_pkg::status_t st;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  aec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  aec_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_ch.valid),
    .in_text_byte     (in_ch.text_byte),
    .in_message_end   (in_ch.message_end),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_kind         (out_ch.kind),
    .out_char         (out_ch.out_char),
    .out_attribute    (out_ch.attribute),
    .out_mode         (out_ch.mode),
    .out_first_param  (out_ch.first_param),
    .out_first_given  (out_ch.first_given),
    .out_second_param (out_ch.second_param),
    .out_second_given (out_ch.second_given),
    .out_last_of_run  (out_ch.last_of_run)
  );

endmodule

`default_nettype wire
